[rtl/sortq_pkg.sv]
package sortq_pkg;

	localparam int DEF_CAPACITY      = 64;
	localparam int DEF_VALUE_BITS    = 16;
	localparam int DEF_PRIORITY_BITS = 16;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_CHANGE = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

endpackage

[rtl/sorted_priority_queue.sv]
// channel   direction  handshake              payload
// command   in         start high, busy low   action, item_value, item_priority
// result    out        done strobe, 1 cycle   status, head_value, head_priority,
//                                             head_valid, entry_count
//
// each transaction runs a memory scan that handles one entry per cycle:
// insert shifts the entries passed over, remove head shifts all the rest up, change
// priority searches, drops, reinserts; refused, empty, unused-action cases skip it
// the next command is taken in the cycle done is shown
// reset clears the entry count and control; entry memory needs no clearing
// the receiver cannot stall: done is high for exactly one cycle
module sorted_priority_queue
	import sortq_pkg::*;
#(
	parameter int CAPACITY      = DEF_CAPACITY,
	parameter int VALUE_BITS    = DEF_VALUE_BITS,
	parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       action,
	input  logic [VALUE_BITS-1:0]            item_value,
	input  logic [PRIORITY_BITS-1:0]         item_priority,
	output logic                             done,
	output logic [1:0]                       status,
	output logic [VALUE_BITS-1:0]            head_value,
	output logic [PRIORITY_BITS-1:0]         head_priority,
	output logic                             head_valid,
	output logic [$clog2(CAPACITY + 1)-1:0]  entry_count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int EW = VALUE_BITS + PRIORITY_BITS;

	logic          mem_rd_en;
	logic [AW-1:0] mem_rd_addr;
	logic [EW-1:0] mem_rd_data;
	logic          mem_wr_en;
	logic [AW-1:0] mem_wr_addr;
	logic [EW-1:0] mem_wr_data;

	sortq_ctrl #(
		.CAPACITY      (CAPACITY),
		.VALUE_BITS    (VALUE_BITS),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.item_value    (item_value),
		.item_priority (item_priority),
		.done          (done),
		.status        (status),
		.head_value    (head_value),
		.head_priority (head_priority),
		.head_valid    (head_valid),
		.entry_count   (entry_count),
		.mem_rd_en     (mem_rd_en),
		.mem_rd_addr   (mem_rd_addr),
		.mem_rd_data   (mem_rd_data),
		.mem_wr_en     (mem_wr_en),
		.mem_wr_addr   (mem_wr_addr),
		.mem_wr_data   (mem_wr_data)
	);

	sortq_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (EW)
	) u_mem (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

endmodule

[rtl/sortq_mem.sv]
module sortq_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/sortq_ctrl.sv]
module sortq_ctrl
	import sortq_pkg::*;
#(
	parameter int CAPACITY      = DEF_CAPACITY,
	parameter int VALUE_BITS    = DEF_VALUE_BITS,
	parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1),
	localparam int EW = VALUE_BITS + PRIORITY_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               action,
	input  logic [VALUE_BITS-1:0]    item_value,
	input  logic [PRIORITY_BITS-1:0] item_priority,
	output logic                     done,
	output logic [1:0]               status,
	output logic [VALUE_BITS-1:0]    head_value,
	output logic [PRIORITY_BITS-1:0] head_priority,
	output logic                     head_valid,
	output logic [CW-1:0]            entry_count,
	output logic                     mem_rd_en,
	output logic [AW-1:0]            mem_rd_addr,
	input  logic [EW-1:0]            mem_rd_data,
	output logic                     mem_wr_en,
	output logic [AW-1:0]            mem_wr_addr,
	output logic [EW-1:0]            mem_wr_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_DROP_RD,
		S_DROP_WR,
		S_SRCH,
		S_HEAD,
		S_OUT
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            occ_q;
	logic [CW-1:0]            k_q;
	logic [VALUE_BITS-1:0]    val_q;
	logic [PRIORITY_BITS-1:0] pri_q;
	logic                     chg_q;
	status_t                  st_q;
	logic                     done_q;
	status_t                  status_q;
	logic [VALUE_BITS-1:0]    hval_q;
	logic [PRIORITY_BITS-1:0] hpri_q;
	logic                     hvalid_q;
	logic [CW-1:0]            count_q;

	logic [CW-1:0]            km1, km2, kp1, kp2, occ_m1;
	logic [VALUE_BITS-1:0]    rd_val;
	logic [PRIORITY_BITS-1:0] rd_pri;
	logic                     rd_match;
	logic                     rd_stays;
	action_t                  act;

	assign km1      = k_q - CW'(1);
	assign km2      = k_q - CW'(2);
	assign kp1      = k_q + CW'(1);
	assign kp2      = k_q + CW'(2);
	assign occ_m1   = occ_q - CW'(1);
	assign rd_val   = mem_rd_data[EW-1:PRIORITY_BITS];
	assign rd_pri   = mem_rd_data[PRIORITY_BITS-1:0];
	assign rd_match = (rd_val == val_q);
	assign rd_stays = (rd_pri >= pri_q);
	assign act      = action_t'(action);
	assign busy     = (state_q != S_IDLE);

	assign done          = done_q;
	assign status        = status_q;
	assign head_value    = hval_q;
	assign head_priority = hpri_q;
	assign head_valid    = hvalid_q;
	assign entry_count   = count_q;

	// memory port control
	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = '0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = k_q[AW-1:0];
		mem_wr_data = {val_q, pri_q};
		unique case (state_q)
			S_IDLE: begin
				if (start && act == ACT_CHANGE && occ_q != '0) begin
					mem_rd_en = 1'b1;
				end
			end
			S_INS_RD: begin
				if (k_q == '0) begin
					mem_wr_en = 1'b1;
				end else begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = km1[AW-1:0];
				end
			end
			S_INS_CMP: begin
				mem_wr_en = 1'b1;
				if (!rd_stays) begin
					mem_wr_data = mem_rd_data;
					if (km1 != '0) begin
						mem_rd_en   = 1'b1;
						mem_rd_addr = km2[AW-1:0];
					end
				end
			end
			S_DROP_RD: begin
				if (kp1 < occ_q) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = kp1[AW-1:0];
				end
			end
			S_DROP_WR: begin
				mem_wr_en   = 1'b1;
				mem_wr_data = mem_rd_data;
				if (kp2 < occ_q) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = kp2[AW-1:0];
				end
			end
			S_SRCH: begin
				if (!rd_match && kp1 < occ_q) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = kp1[AW-1:0];
				end
			end
			S_HEAD: begin
				mem_rd_en = 1'b1;
			end
			S_OUT: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			occ_q    <= '0;
			k_q      <= '0;
			chg_q    <= 1'b0;
			st_q     <= ST_OK;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			hvalid_q <= 1'b0;
			count_q  <= '0;
			val_q    <= '0;
			pri_q    <= '0;
			hval_q   <= '0;
			hpri_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						val_q <= item_value;
						pri_q <= item_priority;
						k_q   <= '0;
						chg_q <= 1'b0;
						st_q  <= ST_OK;
						unique case (act)
							ACT_INSERT: begin
								if (occ_q == CW'(CAPACITY)) begin
									st_q    <= ST_FULL;
									state_q <= S_HEAD;
								end else begin
									k_q     <= occ_q;
									state_q <= S_INS_RD;
								end
							end
							ACT_REMOVE: begin
								if (occ_q == '0) begin
									st_q    <= ST_EMPTY;
									state_q <= S_HEAD;
								end else begin
									state_q <= S_DROP_RD;
								end
							end
							ACT_CHANGE: begin
								chg_q <= 1'b1;
								if (occ_q == '0) begin
									st_q    <= ST_NOT_FOUND;
									state_q <= S_HEAD;
								end else begin
									state_q <= S_SRCH;
								end
							end
							ACT_NONE: begin
								state_q <= S_HEAD;
							end
						endcase
					end
				end
				S_INS_RD: begin
					if (k_q == '0) begin
						occ_q   <= occ_q + CW'(1);
						state_q <= S_HEAD;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (rd_stays) begin
						occ_q   <= occ_q + CW'(1);
						state_q <= S_HEAD;
					end else begin
						k_q <= km1;
						if (km1 == '0) begin
							state_q <= S_INS_RD;
						end
					end
				end
				S_DROP_RD: begin
					if (kp1 < occ_q) begin
						state_q <= S_DROP_WR;
					end else begin
						occ_q <= occ_m1;
						k_q   <= occ_m1;
						state_q <= chg_q ? S_INS_RD : S_HEAD;
					end
				end
				S_DROP_WR: begin
					k_q <= kp1;
					if (!(kp2 < occ_q)) begin
						occ_q <= occ_m1;
						k_q   <= occ_m1;
						state_q <= chg_q ? S_INS_RD : S_HEAD;
					end
				end
				S_SRCH: begin
					if (rd_match) begin
						state_q <= S_DROP_RD;
					end else if (kp1 < occ_q) begin
						k_q <= kp1;
					end else begin
						st_q    <= ST_NOT_FOUND;
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					done_q   <= 1'b1;
					status_q <= st_q;
					count_q  <= occ_q;
					hvalid_q <= (occ_q != '0);
					hval_q   <= (occ_q != '0) ? rd_val : '0;
					hpri_q   <= (occ_q != '0) ? rd_pri : '0;
					state_q  <= S_IDLE;
				end
			endcase
		end
	end

endmodule
